>>> rtl/chpf_pkg.sv
`timescale 1ns / 1ps
// Package for the CRC-32 header packet framer: item codes, status codes,
// header constants, sequencer states and the header byte lookup. No dependencies.
package chpf_pkg;

  localparam int FRAME_LEN_W = 11;
  localparam int CRC_STEP_W  = 4;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_CLOSE  = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_LONG  = 2'd1;
  localparam logic [1:0] STAT_NO_FRAME  = 2'd2;
  localparam logic [1:0] STAT_BUSY      = 2'd3;

  localparam logic [31:0] MAGIC_WORD   = 32'h3157_5245;
  localparam logic [31:0] STREAM_WORD  = 32'h4552_5a57;
  localparam logic [31:0] CRC_POLY     = 32'hedb8_8320;
  localparam logic [31:0] CRC_PRESET   = 32'hffff_ffff;
  localparam logic [15:0] HDR_VERSION  = 16'd1;
  localparam logic [15:0] HDR_KIND     = 16'd48;
  localparam logic [15:0] FLAG_FIRST   = 16'h0001;
  localparam logic [15:0] FLAG_LAST    = 16'h0002;
  localparam logic [15:0] HDR_LEN_WORD = 16'd32;
  localparam int          HDR_BYTES    = 32;
  localparam logic [CRC_STEP_W-1:0] CRC_STEPS = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_MEM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } crc_ctrl_t;

  function automatic logic [7:0] header_byte(input logic [4:0]  pos,
                                             input logic [31:0] seq,
                                             input logic [31:0] len,
                                             input logic [31:0] crc);
    logic [31:0] w;
    case (pos[4:2])
      3'd0:    w = MAGIC_WORD;
      3'd1:    w = {HDR_LEN_WORD, HDR_VERSION};
      3'd2:    w = STREAM_WORD;
      3'd3:    w = seq;
      3'd4:    w = {FLAG_FIRST | FLAG_LAST, HDR_KIND};
      3'd5:    w = len;
      3'd6:    w = ~crc;
      default: w = '0;
    endcase
    return w[{pos[1:0], 3'b000} +: 8];
  endfunction

endpackage

>>> rtl/chpf_crc_unit.sv
`timescale 1ns / 1ps
// Bit-serial reflected CRC-32 unit: one shift and conditional XOR per cycle.
// Depends on chpf_pkg.
module chpf_crc_unit import chpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  crc_ctrl_t   ctrl,
  output logic [31:0] crc,
  output logic        busy
);

  logic [CRC_STEP_W-1:0] steps;

  assign busy = (steps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= CRC_PRESET;
      steps <= '0;
    end else if (ctrl.clear) begin
      crc   <= CRC_PRESET;
      steps <= '0;
    end else if (ctrl.start) begin
      crc   <= crc ^ {24'd0, ctrl.data};
      steps <= CRC_STEPS;
    end else if (busy) begin
      crc   <= (crc >> 1) ^ (CRC_POLY & {32{crc[0]}});
      steps <= steps - 1'b1;
    end
  end

endmodule

>>> rtl/chpf_buffer.sv
`timescale 1ns / 1ps
// Payload buffer: single write port and one registered read port.
// No dependencies.
module chpf_buffer #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/crc32_header_packet_framer.sv
`timescale 1ns / 1ps
// Packet framer: payload bytes are buffered and folded into a reflected CRC-32,
// a close item seals a 32-byte header, and read items return the frame a byte at
// a time. The block works on one item at a time and drops cmd_stall once the
// result has moved into the output register. An append that is stored waits in
// the CRC state until the bit-serial CRC unit, which shifts one bit per cycle,
// is done; a payload read passes through the memory state for the registered
// read port of the buffer; every other item goes straight to the done state.
// A result waits in the output register while the next item is taken. The
// buffer needs no clearing after reset, so items are accepted from the first cycle.
// Depends on chpf_pkg, chpf_crc_unit and chpf_buffer.
module crc32_header_packet_framer import chpf_pkg::*; #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  logic [1:0]             func,
  input  logic [7:0]             data_byte,
  input  logic [31:0]            sequence_req,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [1:0]             status,
  output logic [7:0]             frame_byte,
  output logic                   frame_last,
  output logic [FRAME_LEN_W-1:0] frame_length
);

  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int POS_W  = $clog2(MAX_PAYLOAD + HDR_BYTES + 1);
  localparam int TOT_W  = (POS_W > FRAME_LEN_W) ? POS_W : FRAME_LEN_W;

  state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic             ovf, ovf_next;
  logic             sealed, sealed_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [31:0]      seq, seq_next;

  logic [1:0]             r_status, r_status_next;
  logic [7:0]             r_byte, r_byte_next;
  logic                   r_last, r_last_next;
  logic [FRAME_LEN_W-1:0] r_len, r_len_next;

  crc_ctrl_t        crc_ctrl;
  logic [31:0]      crc;
  logic             crc_busy;
  logic             wr_en;
  logic             rd_en;
  logic [7:0]       rd_data;
  logic             out_load;
  logic             accept;
  logic [TOT_W-1:0] total;
  logic [POS_W-1:0] idx;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign total     = TOT_W'(HDR_BYTES) + TOT_W'(count);
  assign idx       = pos - POS_W'(HDR_BYTES);

  chpf_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .crc  (crc),
    .busy (crc_busy)
  );

  chpf_buffer #(
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (ADDR_W)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_next      = ovf;
    sealed_next   = sealed;
    pos_next      = pos;
    seq_next      = seq;
    r_status_next = r_status;
    r_byte_next   = r_byte;
    r_last_next   = r_last;
    r_len_next    = r_len;
    crc_ctrl      = '0;
    crc_ctrl.data = data_byte;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          r_status_next = STAT_OK;
          r_byte_next   = '0;
          r_last_next   = 1'b0;
          r_len_next    = '0;
          state_next    = ST_DONE;
          case (func)
            FUNC_APPEND: begin
              if (sealed) begin
                r_status_next = STAT_BUSY;
              end else if (count < CNT_W'(MAX_PAYLOAD)) begin
                wr_en          = 1'b1;
                crc_ctrl.start = 1'b1;
                count_next     = count + 1'b1;
                state_next     = ST_CRC;
              end else begin
                ovf_next      = 1'b1;
                r_status_next = STAT_TOO_LONG;
              end
            end
            FUNC_CLOSE: begin
              if (sealed) begin
                r_status_next = STAT_BUSY;
              end else if (ovf) begin
                count_next     = '0;
                crc_ctrl.clear = 1'b1;
                ovf_next       = 1'b0;
                sealed_next    = 1'b0;
                pos_next       = '0;
                r_status_next  = STAT_TOO_LONG;
              end else begin
                seq_next    = sequence_req;
                sealed_next = 1'b1;
                pos_next    = '0;
                r_len_next  = total[FRAME_LEN_W-1:0];
              end
            end
            FUNC_READ: begin
              if (!sealed) begin
                r_status_next = STAT_NO_FRAME;
              end else begin
                if (pos < POS_W'(HDR_BYTES)) begin
                  r_byte_next = header_byte(pos[4:0], seq, 32'(count), crc);
                end else begin
                  rd_en      = 1'b1;
                  state_next = ST_MEM;
                end
                if (TOT_W'(pos) + 1'b1 >= total) begin
                  r_last_next    = 1'b1;
                  count_next     = '0;
                  crc_ctrl.clear = 1'b1;
                  ovf_next       = 1'b0;
                  sealed_next    = 1'b0;
                  pos_next       = '0;
                end else begin
                  pos_next = pos + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CRC: begin
        if (!crc_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_MEM: begin
        r_byte_next = rd_data;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ovf    <= 1'b0;
      sealed <= 1'b0;
      pos    <= '0;
      seq    <= '0;
    end else begin
      count  <= count_next;
      ovf    <= ovf_next;
      sealed <= sealed_next;
      pos    <= pos_next;
      seq    <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    r_status <= r_status_next;
    r_byte   <= r_byte_next;
    r_last   <= r_last_next;
    r_len    <= r_len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= r_status;
      frame_byte   <= r_byte;
      frame_last   <= r_last;
      frame_length <= r_len;
    end
  end

  a_no_accept_in_crc: assert property (@(posedge clk) disable iff (rst)
    crc_busy |-> cmd_stall)
    else $error("item accepted while the CRC unit is still shifting");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_DONE)
    else $error("result presented without passing through the done state");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PAYLOAD))
    else $error("payload count beyond buffer size");

  a_sealed_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(sealed && ovf))
    else $error("sealed frame with overflow flag set");

endmodule
